### rtl/core/lds_pkg.sv
// Shared types, constants and helpers for the LOOK disk scheduler.
// Used by lds_cell and look_disk_scheduler; depends on nothing else.
package lds_pkg;

  localparam int MAX_BATCH  = 63;
  localparam int CYL_BITS   = 12;
  localparam int SEEK_BITS  = 14;
  localparam int COUNT_BITS = 6;
  localparam int KEY_BITS   = CYL_BITS + 1;

  localparam logic [SEEK_BITS-1:0] SEEK_MAX = {SEEK_BITS{1'b1}};

  // Configuration register indexes.
  localparam logic CFG_START   = 1'b0;
  localparam logic CFG_MOVE_UP = 1'b1;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic load;     // write the incoming request into this cell
    logic pair_en;  // this cell and its upper neighbour form a compare pair
    logic shift;    // take the upper neighbour's value (drain towards cell 0)
  } lds_cell_ctl_t;

  // Service-order key: ascending keys give the LOOK visiting order.
  // The top bit separates the first sweep from the return sweep; the upward
  // return sweep and the downward first sweep are ordered on the inverted cylinder.
  function automatic logic [KEY_BITS-1:0] look_key(input logic [CYL_BITS-1:0] cyl,
                                                   input logic [CYL_BITS-1:0] start,
                                                   input logic            up);
    logic [KEY_BITS-1:0] k;
    if (up) begin
      k = (cyl >= start) ? {1'b0, cyl} : {1'b1, ~cyl};
    end else begin
      k = (cyl <= start) ? {1'b0, ~cyl} : {1'b1, cyl};
    end
    return k;
  endfunction

endpackage

### rtl/core/lds_cell.sv
// One cell of the request chain: holds a cylinder and compare-swaps it
// with its upper neighbour. Depends on lds_pkg.
module lds_cell
  import lds_pkg::*;
(
  input  logic                clk,
  input  lds_cell_ctl_t       ctl,
  input  logic [CYL_BITS-1:0] din,
  input  logic [CYL_BITS-1:0] start,
  input  logic                move_up,
  input  logic [CYL_BITS-1:0] lower_val,
  input  logic                lower_swap,
  input  logic [CYL_BITS-1:0] upper_val,
  input  logic [KEY_BITS-1:0] upper_key,
  output logic [CYL_BITS-1:0] val,
  output logic [KEY_BITS-1:0] key,
  output logic                swap
);

  // Key of the held cylinder and the exchange decision with the upper cell.
  assign key  = look_key(val, start, move_up);
  assign swap = ctl.pair_en && (key > upper_key);

  // Value update: load, drain, or exchange with either neighbour.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      val <= din;
    end else if (ctl.shift || swap) begin
      val <= upper_val;
    end else if (lower_swap) begin
      val <= lower_val;
    end
  end

endmodule

### rtl/core/look_disk_scheduler.sv
// LOOK disk scheduler: collects a batch of requests in a chain of cells,
// sorts them by odd-even transposition and streams out the service order.
// Requests are accepted while the block is loading. After the final request the chain
// runs n sort rounds (n = stored requests), then emits n+1 results at 1 per cycle
// while the receiver is ready.
// Synchronous active-high reset clears the count, state and configuration.
module look_disk_scheduler
  import lds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] cylinder, [15:12] zero
  input  logic        s_tlast,   // batch_end
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [11:0] served_cylinder, [25:12] seek_so_far, [31:26] zero
  output logic        m_tlast,   // sequence_end
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]            state;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic [COUNT_BITS-1:0] rounds;
  logic [COUNT_BITS-1:0] remain;
  logic                  phase;
  logic                  first;
  logic [CYL_BITS-1:0]   cfg_start;
  logic                  cfg_up;
  logic [CYL_BITS-1:0]   start_reg;
  logic                  up_reg;
  logic [CYL_BITS-1:0]   out_cyl;
  logic [SEEK_BITS-1:0]  out_seek;
  logic                  out_last;
  logic                  out_valid;
  logic                  in_fire;
  logic                  out_load;
  logic                  drain;
  logic [CYL_BITS-1:0]   head_gap;
  logic [SEEK_BITS:0]    seek_sum;
  logic [SEEK_BITS-1:0]  seek_next;

  logic [CYL_BITS-1:0]   val   [MAX_BATCH];
  logic [KEY_BITS-1:0]   key   [MAX_BATCH];
  logic                  swp   [MAX_BATCH];
  lds_cell_ctl_t         ctl   [MAX_BATCH];

  // Handshakes.
  assign s_tready  = (state == ST_LOAD);
  assign cfg_ready = 1'b1;
  assign in_fire   = s_tvalid && s_tready;
  assign out_load  = (state == ST_EMIT) && (!out_valid || m_tready);
  assign drain     = out_load && !first;

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(32 - CYL_BITS - SEEK_BITS){1'b0}}, out_seek, out_cyl};
  assign m_tlast  = out_last;

  // Count after the current request is stored; a full store drops it.
  assign count_next = (count != COUNT_BITS'(MAX_BATCH)) ? count + 1'b1 : count;

  // Distance from the current head position to the cell at the chain head.
  assign head_gap  = (val[0] >= out_cyl) ? val[0] - out_cyl : out_cyl - val[0];
  assign seek_sum  = {1'b0, out_seek} + (SEEK_BITS + 1)'(head_gap);
  assign seek_next = seek_sum[SEEK_BITS] ? SEEK_MAX : seek_sum[SEEK_BITS-1:0];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_start <= '0;
      cfg_up    <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START:   cfg_start <= cfg_data;
        CFG_MOVE_UP: cfg_up    <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  // Chain of cells.
  for (genvar i = 0; i < MAX_BATCH; i++) begin : g_cell
    localparam logic [COUNT_BITS:0] NEXT_IDX = (COUNT_BITS + 1)'(i + 1);
    localparam logic                PAR      = 1'(i % 2);
    logic [CYL_BITS-1:0] lo_val;
    logic                lo_swap;
    logic [CYL_BITS-1:0] up_val;
    logic [KEY_BITS-1:0] up_key;

    if (i == 0) begin : g_bottom
      assign lo_val  = '0;
      assign lo_swap = 1'b0;
    end else begin : g_inner_lo
      assign lo_val  = val[i-1];
      assign lo_swap = swp[i-1];
    end
    if (i == MAX_BATCH - 1) begin : g_top
      assign up_val = val[i];
      assign up_key = '1;
    end else begin : g_inner_up
      assign up_val = val[i+1];
      assign up_key = key[i+1];
    end

    assign ctl[i].load    = in_fire && (count == COUNT_BITS'(i))
                            && (count != COUNT_BITS'(MAX_BATCH));
    assign ctl[i].pair_en = (state == ST_SORT) && (phase == PAR)
                            && (NEXT_IDX < {1'b0, count});
    assign ctl[i].shift   = drain;

    lds_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[i]),
      .din        (s_tdata[CYL_BITS-1:0]),
      .start      (start_reg),
      .move_up    (up_reg),
      .lower_val  (lo_val),
      .lower_swap (lo_swap),
      .upper_val  (up_val),
      .upper_key  (up_key),
      .val        (val[i]),
      .key        (key[i]),
      .swap       (swp[i])
    );
  end

  // Sequencer: load, sort rounds, emission.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      rounds    <= '0;
      remain    <= '0;
      phase     <= 1'b0;
      first     <= 1'b0;
      start_reg <= '0;
      up_reg    <= 1'b1;
    end else begin
      case (state)
        ST_LOAD: begin
          if (in_fire) begin
            count <= count_next;
            if (s_tlast) begin
              state     <= ST_SORT;
              rounds    <= count_next;
              phase     <= 1'b0;
              start_reg <= cfg_start;
              up_reg    <= cfg_up;
            end
          end
        end
        ST_SORT: begin
          phase  <= ~phase;
          rounds <= rounds - 1'b1;
          if (rounds == COUNT_BITS'(1)) begin
            state  <= ST_EMIT;
            first  <= 1'b1;
            remain <= count;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            if (first) begin
              first <= 1'b0;
            end else begin
              remain <= remain - 1'b1;
              if (remain == COUNT_BITS'(1)) begin
                state <= ST_LOAD;
                count <= '0;
              end
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // Output register; its cylinder and seek double as head position and total.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (first) begin
        out_cyl  <= start_reg;
        out_seek <= '0;
        out_last <= 1'b0;
      end else begin
        out_cyl  <= val[0];
        out_seek <= seek_next;
        out_last <= (remain == COUNT_BITS'(1));
      end
    end
  end

  // Checks on the sequencer.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_BITS'(MAX_BATCH))
    else $error("request count beyond store depth");

  a_rounds_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SORT) |-> (rounds != '0 && rounds <= count))
    else $error("sort round counter out of range");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && !first) |-> (remain != '0))
    else $error("emission with no requests left");

  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    (out_load && !first && remain == COUNT_BITS'(1)) |=> (state == ST_LOAD && count == '0))
    else $error("block did not return to loading after the final result");

endmodule

### sim/look_disk_scheduler_tb.sv
// Self-checking testbench for look_disk_scheduler: drives request batches and register
// writes, predicts the LOOK service order and checks every result transaction.
// Depends on lds_pkg and the look_disk_scheduler RTL only.
`timescale 1ns / 100ps

module look_disk_scheduler_tb;
  import lds_pkg::*;

  localparam int RAND_ITEMS  = 340;
  localparam int CALM_ITEMS  = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;
  localparam int TAIL        = 2 * MAX_BATCH + 16;
  localparam int STALL_LIMIT = 4000;
  localparam int DIR_ROWS    = 19;

  // One result transaction: sequence_end, seek_so_far, served_cylinder.
  typedef struct packed {
    logic                 last;
    logic [SEEK_BITS-1:0] seek;
    logic [CYL_BITS-1:0]  cyl;
  } seek_pos_t;

  // One row of the directed table; reps requests advance the cylinder by stride
  // and only the final one carries the row's batch_end.
  typedef struct packed {
    bit                  set_cfg;
    logic [CYL_BITS-1:0] start;
    bit                  up;
    logic [CYL_BITS-1:0] cyl;
    bit                  last;
    int                  reps;
    int                  stride;
    int                  n_typed;
    seek_pos_t           t0;
    seek_pos_t           t1;
  } dir_row_t;

  localparam seek_pos_t NO_POS = '0;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [11:0] cylinder, [15:12] zero
  logic        s_tlast;   // batch_end
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [11:0] served_cylinder, [25:12] seek_so_far, [31:26] zero
  logic        m_tlast;   // sequence_end
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [11:0] cfg_data;

  // Predictor state, kept in step with the block's accepted transactions.
  logic [CYL_BITS-1:0] request_store [MAX_BATCH];
  int                  stored_count;
  logic [CYL_BITS-1:0] look_start;
  logic                look_up;
  seek_pos_t           service_plan_q [$];
  seek_pos_t           typed_plan_q [$];

  // Run control and statistics.
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_req;
  int  bad_results;
  int  requests_sent;
  int  batches_sent;
  int  results_checked;
  int  reg_writes;
  int  dropped_requests;
  int  long_holds;
  int  sender_pauses;

  dir_row_t dir_steps [DIR_ROWS] = '{
    // After reset: start 0, upward sweep, one request at the top cylinder.
    '{1'b0, 12'd0, 1'b0, 12'd4095, 1'b1, 1, 0, 2,
      '{1'b0, 14'd0, 12'd0}, '{1'b1, 14'd4095, 12'd4095}},
    // Top start moving down to cylinder 0.
    '{1'b1, 12'd4095, 1'b0, 12'd0, 1'b1, 1, 0, 2,
      '{1'b0, 14'd0, 12'd4095}, '{1'b1, 14'd4095, 12'd0}},
    // Start 0 moving down: the request lies on the return sweep.
    '{1'b1, 12'd0, 1'b0, 12'd4095, 1'b1, 1, 0, 2,
      '{1'b0, 14'd0, 12'd0}, '{1'b1, 14'd4095, 12'd4095}},
    // Top start moving up: the request lies on the return sweep.
    '{1'b1, 12'd4095, 1'b1, 12'd0, 1'b1, 1, 0, 2,
      '{1'b0, 14'd0, 12'd4095}, '{1'b1, 14'd4095, 12'd0}},
    // Request equal to the start while moving down.
    '{1'b1, 12'd2048, 1'b0, 12'd2048, 1'b1, 1, 0, 2,
      '{1'b0, 14'd0, 12'd2048}, '{1'b1, 14'd0, 12'd2048}},
    // Mixed batch with a duplicate of the start, upward sweep.
    '{1'b1, 12'd2048, 1'b1, 12'd2048, 1'b0, 1, 0, 0, NO_POS, NO_POS},
    '{1'b0, 12'd0,    1'b0, 12'd100,  1'b0, 1, 0, 0, NO_POS, NO_POS},
    '{1'b0, 12'd0,    1'b0, 12'd3000, 1'b0, 1, 0, 0, NO_POS, NO_POS},
    '{1'b0, 12'd0,    1'b0, 12'd2048, 1'b0, 1, 0, 0, NO_POS, NO_POS},
    '{1'b0, 12'd0,    1'b0, 12'd4000, 1'b1, 1, 0, 0, NO_POS, NO_POS},
    // Neighbours of the start, downward sweep.
    '{1'b1, 12'd2048, 1'b0, 12'd2048, 1'b0, 1, 0, 0, NO_POS, NO_POS},
    '{1'b0, 12'd0,    1'b0, 12'd100,  1'b0, 1, 0, 0, NO_POS, NO_POS},
    '{1'b0, 12'd0,    1'b0, 12'd3000, 1'b0, 1, 0, 0, NO_POS, NO_POS},
    '{1'b0, 12'd0,    1'b0, 12'd2047, 1'b0, 1, 0, 0, NO_POS, NO_POS},
    '{1'b0, 12'd0,    1'b0, 12'd2049, 1'b1, 1, 0, 0, NO_POS, NO_POS},
    // Store overflow: three requests beyond a full store, the last ending the batch.
    '{1'b1, 12'd1000, 1'b1, 12'd5, 1'b1, MAX_BATCH + 3, 61, 0, NO_POS, NO_POS},
    // Largest travel: both ends of the disk from the top, moving down.
    '{1'b1, 12'd4095, 1'b0, 12'd0,    1'b0, 1, 0, 0, NO_POS, NO_POS},
    '{1'b0, 12'd0,    1'b0, 12'd4095, 1'b0, 1, 0, 0, NO_POS, NO_POS},
    '{1'b0, 12'd0,    1'b0, 12'd0,    1'b1, 1, 0, 0, NO_POS, NO_POS}
  };

  look_disk_scheduler DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stores one accepted request and, at the end of a batch, plans its service order.
  task automatic take_request(input logic [CYL_BITS-1:0] cyl, input logic end_b);
    logic [CYL_BITS-1:0] srt [MAX_BATCH];
    logic [CYL_BITS-1:0] visit [$];
    logic [CYL_BITS-1:0] key;
    logic [CYL_BITS-1:0] pos;
    seek_pos_t           plan [$];
    seek_pos_t           step;
    int                  n;
    int                  i;
    int                  j;
    int                  travel;
    int                  hop;
    if (stored_count < MAX_BATCH) begin
      request_store[stored_count] = cyl;
      stored_count++;
    end else begin
      dropped_requests++;
    end
    if (!end_b) return;

    // Ascending copy of the stored requests.
    n = stored_count;
    for (i = 0; i < n; i++) srt[i] = request_store[i];
    for (i = 1; i < n; i++) begin
      key = srt[i];
      j = i;
      while (j > 0 && srt[j-1] > key) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = key;
    end

    // First sweep, then the return sweep.
    if (look_up) begin
      for (i = 0; i < n; i++) if (srt[i] >= look_start) visit.push_back(srt[i]);
      for (i = n - 1; i >= 0; i--) if (srt[i] < look_start) visit.push_back(srt[i]);
    end else begin
      for (i = n - 1; i >= 0; i--) if (srt[i] <= look_start) visit.push_back(srt[i]);
      for (i = 0; i < n; i++) if (srt[i] > look_start) visit.push_back(srt[i]);
    end

    // Head positions with the saturating running seek total.
    step.cyl  = look_start;
    step.seek = '0;
    step.last = (visit.size() == 0);
    plan.push_back(step);
    pos    = look_start;
    travel = 0;
    for (i = 0; i < visit.size(); i++) begin
      hop    = (visit[i] >= pos) ? int'(visit[i]) - int'(pos) : int'(pos) - int'(visit[i]);
      travel = (travel + hop > int'(SEEK_MAX)) ? int'(SEEK_MAX) : travel + hop;
      pos    = visit[i];
      step.cyl  = pos;
      step.seek = SEEK_BITS'(travel);
      step.last = (i == visit.size() - 1);
      plan.push_back(step);
    end
    stored_count = 0;

    // Directed rows may carry their results typed in by hand.
    if (typed_plan_q.size() != 0) begin
      foreach (typed_plan_q[i]) service_plan_q.push_back(typed_plan_q[i]);
      typed_plan_q.delete();
    end else begin
      foreach (plan[i]) service_plan_q.push_back(plan[i]);
    end
  endtask

  // Sample all three channels at the clock edge: predict, follow registers, check results.
  always @(posedge clk) begin
    seek_pos_t got;
    seek_pos_t want;
    if (rst) begin
      stored_count = 0;
      look_start   = '0;
      look_up      = 1'b1;
    end else begin
      if (s_tvalid && s_tready) take_request(s_tdata[CYL_BITS-1:0], s_tlast);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_START) look_start = cfg_data[CYL_BITS-1:0];
        else look_up = cfg_data[0];
      end
      if (m_tvalid && m_tready) begin
        got.cyl  = m_tdata[11:0];
        got.seek = m_tdata[25:12];
        got.last = m_tlast;
        results_checked++;
        if (service_plan_q.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("ERROR %0t: unexpected result cyl=%0d seek=%0d last=%0b",
                     $realtime, got.cyl, got.seek, got.last);
        end else begin
          want = service_plan_q.pop_front();
          if (got.cyl !== want.cyl || got.seek !== want.seek || got.last !== want.last) begin
            bad_results++;
            if (bad_results <= 10)
              $display("ERROR %0t: cyl %0d/%0d seek %0d/%0d last %0b/%0b (expected/actual)",
                       $realtime, want.cyl, got.cyl, want.seek, got.seek, want.last, got.last);
          end
        end
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no transaction on any channel.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // Result receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        long_holds++;
      end else if (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Offers one request and waits for its transaction; may then idle for a burst.
  task automatic send_request(input logic [CYL_BITS-1:0] cyl, input logic end_b);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {4'd0, cyl};
    s_tlast  <= end_b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    requests_sent++;
    if (end_b) batches_sent++;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 10);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lowers the request valid and waits until every planned result has arrived.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (service_plan_q.size() != 0) @(posedge clk);
  endtask

  // Writes one register; the caller lowers cfg_valid after its last write.
  task automatic write_reg(input logic idx, input logic [11:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
  endtask

  // Writes both registers once the block has gone idle.
  task automatic set_look(input logic [CYL_BITS-1:0] start, input logic up);
    drain_results();
    repeat (SETTLE) @(posedge clk);
    write_reg(CFG_START, start);
    write_reg(CFG_MOVE_UP, {11'd0, up});
    cfg_valid <= 1'b0;
  endtask

  // Main sequence: reset, directed table, random batches, final drain and verdict.
  initial begin
    int                  r;
    int                  k;
    int                  rand_sent;
    int                  batch_no;
    int                  blen;
    int                  pick;
    int                  near;
    logic [CYL_BITS-1:0] cyl;
    logic [CYL_BITS-1:0] prev;
    logic [CYL_BITS-1:0] cur_start;

    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tlast       = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_START;
    cfg_data      = '0;
    hold_req      = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    prev          = '0;
    cur_start     = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed table.
    for (r = 0; r < DIR_ROWS; r++) begin
      if (dir_steps[r].set_cfg) set_look(dir_steps[r].start, dir_steps[r].up);
      if (dir_steps[r].n_typed > 0) typed_plan_q.push_back(dir_steps[r].t0);
      if (dir_steps[r].n_typed > 1) typed_plan_q.push_back(dir_steps[r].t1);
      for (k = 0; k < dir_steps[r].reps; k++)
        send_request(CYL_BITS'(dir_steps[r].cyl + k * dir_steps[r].stride),
                     dir_steps[r].last && (k == dir_steps[r].reps - 1));
    end

    // Random batches; mostly short, a few that fill or overflow the store.
    rand_sent = 0;
    batch_no  = 0;
    while (rand_sent < RAND_ITEMS) begin
      if (rand_sent >= RAND_ITEMS - CALM_ITEMS) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 20;
        recv_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 20;
      end

      // New settings only while the block is idle, and not during the hold-off.
      if ((batch_no < 6 || batch_no > 9) && (batch_no == 0 || $urandom_range(0, 3) == 0)) begin
        pick = $urandom_range(0, 4);
        cur_start = (pick == 0) ? '0 : (pick == 1) ? '1 : CYL_BITS'($urandom_range(0, 4095));
        set_look(cur_start, 1'($urandom_range(0, 1)));
      end
      if (batch_no == 6) hold_req = 1'b1;
      if (batch_no == 14) begin
        drain_results();
        sender_pauses++;
      end

      pick = $urandom_range(0, 99);
      if (pick < 70)      blen = $urandom_range(1, 8);
      else if (pick < 90) blen = $urandom_range(9, 24);
      else if (pick < 97) blen = MAX_BATCH;
      else                blen = $urandom_range(MAX_BATCH + 1, MAX_BATCH + 7);
      if (batch_no >= 6 && batch_no <= 8) blen = 20;

      for (k = 0; k < blen; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          cyl = CYL_BITS'($urandom_range(0, 4095));
        end else if (pick < 60) begin
          near = int'(cur_start) + int'($urandom_range(0, 80)) - 40;
          cyl  = (near < 0) ? '0 : (near > 4095) ? '1 : CYL_BITS'(near);
        end else if (pick < 75) begin
          cyl = $urandom_range(0, 1) ? '1 : '0;
        end else begin
          cyl = prev;
        end
        prev = cyl;
        send_request(cyl, k == blen - 1);
        rand_sent++;
      end
      batch_no++;
    end

    // Let everything drain, then watch for stray results.
    drain_results();
    repeat (TAIL) @(posedge clk);

    $display("Run covered %0d requests in %0d batches with %0d results checked",
             requests_sent, batches_sent, results_checked);
    $display("and %0d register writes, %0d dropped requests, %0d long hold-offs, %0d pauses.",
             reg_writes, dropped_requests, long_holds, sender_pauses);
    if (bad_results == 0 && service_plan_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d bad results, %0d results still outstanding",
               bad_results, service_plan_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
